@@ rtl/rwcf_pkg.sv @@
// Shared types, constants and helpers for the random-walk crossfader.
// No dependencies; imported by rwcf_mix, rwcf_ramp and the top level.
`default_nettype none

package rwcf_pkg;

	// Sample and fixed-point format
	localparam int SAMPLE_BITS = 16;
	localparam int FRAC_BITS   = 15;

	// Field widths fixed by the interface
	localparam int WEIGHT_W = 17;
	localparam int ALPHA_W  = 16;
	localparam int TICK_W   = 8;
	localparam int LFSR_W   = 16;
	localparam int PHASE_W  = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Mix datapath widths
	localparam int DIFF_W = SAMPLE_BITS + 1;
	localparam int PROD_W = DIFF_W + WEIGHT_W;
	localparam int Q_W    = PROD_W - FRAC_BITS;
	localparam int SUM_W  = Q_W + 1;

	// Target and compare widths
	localparam int TGT_W = FRAC_BITS;
	localparam int CMP_W = (TGT_W + 1 > WEIGHT_W) ? TGT_W + 1 : WEIGHT_W;

	// Reset values
	localparam logic [ALPHA_W-1:0]  START_ALPHA_RST = ALPHA_W'(19661);
	localparam logic [TICK_W-1:0]   TRANS_TICKS_RST = TICK_W'(3);
	localparam logic [TICK_W-1:0]   INCR_TICKS_RST  = TICK_W'(1);
	localparam logic [ALPHA_W-1:0]  STEP_SIZE_RST   = ALPHA_W'(983);
	localparam logic [LFSR_W-1:0]   LFSR_SEED_RST   = LFSR_W'(44257);
	localparam logic [LFSR_W-1:0]   LFSR_TAPS       = LFSR_W'(16'hB400);

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_START_ALPHA = 3'd0,
		CFG_TRANS_TICKS = 3'd1,
		CFG_INCR_TICKS  = 3'd2,
		CFG_STEP_SIZE   = 3'd3,
		CFG_LFSR_SEED   = 3'd4
	} cfg_idx_t;

	// Ramp phases, one-hot
	typedef enum logic [3:0] {
		PH_WAIT = 4'b0001,
		PH_FALL = 4'b0010,
		PH_RISE = 4'b0100,
		PH_DROP = 4'b1000
	} phase_t;

	// Output phase codes
	localparam logic [PHASE_W-1:0] CODE_WAIT = 2'd0;
	localparam logic [PHASE_W-1:0] CODE_FALL = 2'd1;
	localparam logic [PHASE_W-1:0] CODE_RISE = 2'd2;
	localparam logic [PHASE_W-1:0] CODE_DROP = 2'd3;

	// Ramp timing configuration
	typedef struct packed {
		logic [TICK_W-1:0]  transition_ticks;
		logic [TICK_W-1:0]  increment_ticks;
		logic [ALPHA_W-1:0] step_size;
	} rwcf_cfg_t;

	// State loads caused by register writes
	typedef struct packed {
		logic                  weight_ld;
		logic                  lfsr_ld;
		logic [CFG_DATA_W-1:0] data;
	} rwcf_load_t;

	function automatic logic [PHASE_W-1:0] phase_code(input phase_t ph);
		logic [PHASE_W-1:0] code;
		unique case (ph)
			PH_WAIT: code = CODE_WAIT;
			PH_FALL: code = CODE_FALL;
			PH_RISE: code = CODE_RISE;
			PH_DROP: code = CODE_DROP;
			default: code = CODE_WAIT;
		endcase
		return code;
	endfunction

endpackage

`default_nettype wire

@@ rtl/rwcf_mix.sv @@
// Crossfade datapath: a + round((b - a) * weight), saturated to sample width.
// Depends on rwcf_pkg.
`default_nettype none

module rwcf_mix
	import rwcf_pkg::*;
(
	input  wire logic signed [SAMPLE_BITS-1:0] sample_a,
	input  wire logic signed [SAMPLE_BITS-1:0] sample_b,
	input  wire logic signed [WEIGHT_W-1:0]    weight,
	output logic signed [SAMPLE_BITS-1:0]      mixed
);

	localparam logic signed [PROD_W-1:0] ROUND_C = PROD_W'(2 ** (FRAC_BITS - 1));
	localparam logic signed [SUM_W-1:0]  SAT_HI  = SUM_W'(2 ** (SAMPLE_BITS - 1) - 1);
	localparam logic signed [SUM_W-1:0]  SAT_LO  = -SAT_HI - SUM_W'(1);

	logic signed [DIFF_W-1:0] diff;
	logic signed [PROD_W-1:0] prod;
	logic signed [PROD_W-1:0] prod_rnd;
	logic signed [Q_W-1:0]    quot;
	logic signed [SUM_W-1:0]  sum;

	always_comb begin
		diff     = DIFF_W'(sample_b) - DIFF_W'(sample_a);
		prod     = PROD_W'(diff) * PROD_W'(weight);
		prod_rnd = prod + ROUND_C;
		// floor shift: drop the fraction bits of a two's complement value
		quot     = signed'(prod_rnd[PROD_W-1:FRAC_BITS]);
		sum      = SUM_W'(sample_a) + SUM_W'(quot);
		if (sum > SAT_HI) begin
			mixed = SAT_HI[SAMPLE_BITS-1:0];
		end else if (sum < SAT_LO) begin
			mixed = SAT_LO[SAMPLE_BITS-1:0];
		end else begin
			mixed = sum[SAMPLE_BITS-1:0];
		end
	end

endmodule

`default_nettype wire

@@ rtl/rwcf_ramp.sv @@
// Mix weight ramp controller: tick counter, phase FSM, LFSR target draw.
// Depends on rwcf_pkg.
`default_nettype none

module rwcf_ramp
	import rwcf_pkg::*;
(
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire rwcf_cfg_t                  cfg,
	input  wire rwcf_load_t                 load,
	input  wire logic                       tick,      // item in hand is a tick
	input  wire logic                       commit,    // item in hand moves on
	output logic signed [WEIGHT_W-1:0]      weight_cur,
	output logic signed [WEIGHT_W-1:0]      weight_post,
	output logic [PHASE_W-1:0]              phase_post
);

	localparam logic signed [WEIGHT_W+1-1:0] W_MAX = (WEIGHT_W + 1)'(2 ** (WEIGHT_W - 1) - 1);
	localparam logic signed [WEIGHT_W+1-1:0] W_MIN = -W_MAX - (WEIGHT_W + 1)'(1);

	logic signed [WEIGHT_W-1:0] weight_q, weight_n;
	phase_t                     phase_q, phase_n;
	logic [TICK_W-1:0]          cnt_q, cnt_n, cnt_inc, len_raw, len_eff;
	logic [TGT_W-1:0]           tgt_q, tgt_n, tgt_draw;
	logic [LFSR_W-1:0]          lfsr_q, lfsr_n, lfsr_draw;
	logic [LFSR_W+FRAC_BITS-1:0] tgt_wide;
	logic signed [WEIGHT_W:0]   sum_up, sum_dn;
	logic signed [WEIGHT_W-1:0] w_up, w_dn;
	logic signed [CMP_W-1:0]    w_cmp, tq_cmp, td_cmp;

	always_comb begin
		// saturating steps
		sum_up = (WEIGHT_W + 1)'(weight_q) + signed'((WEIGHT_W + 1)'(cfg.step_size));
		sum_dn = (WEIGHT_W + 1)'(weight_q) - signed'((WEIGHT_W + 1)'(cfg.step_size));
		w_up   = (sum_up > W_MAX) ? W_MAX[WEIGHT_W-1:0] : sum_up[WEIGHT_W-1:0];
		w_dn   = (sum_dn < W_MIN) ? W_MIN[WEIGHT_W-1:0] : sum_dn[WEIGHT_W-1:0];

		// Galois LFSR advance and scaled target
		lfsr_draw = (lfsr_q >> 1) ^ (lfsr_q[0] ? LFSR_TAPS : '0);
		tgt_wide  = {lfsr_draw, FRAC_BITS'(0)};
		tgt_draw  = tgt_wide[LFSR_W+FRAC_BITS-1:LFSR_W];

		w_cmp  = CMP_W'(weight_q);
		tq_cmp = signed'(CMP_W'(tgt_q));
		td_cmp = signed'(CMP_W'(tgt_draw));

		len_raw = (phase_q == PH_WAIT) ? cfg.transition_ticks : cfg.increment_ticks;
		len_eff = (len_raw == '0) ? TICK_W'(1) : len_raw;
		cnt_inc = cnt_q + TICK_W'(1);

		weight_n = weight_q;
		phase_n  = phase_q;
		cnt_n    = cnt_q;
		tgt_n    = tgt_q;
		lfsr_n   = lfsr_q;

		if (tick) begin
			if (cnt_inc < len_eff) begin
				cnt_n = cnt_inc;
			end else begin
				cnt_n = '0;
				unique case (phase_q)
					PH_WAIT, PH_FALL: begin
						if (weight_q > 0) begin
							weight_n = w_dn;
							phase_n  = PH_FALL;
						end else begin
							lfsr_n = lfsr_draw;
							tgt_n  = tgt_draw;
							if (td_cmp > w_cmp) begin
								weight_n = w_up;
								phase_n  = PH_RISE;
							end else if (td_cmp < w_cmp) begin
								weight_n = w_dn;
								phase_n  = PH_DROP;
							end else begin
								phase_n = PH_WAIT;
							end
						end
					end
					PH_RISE: begin
						if (tq_cmp > w_cmp) weight_n = w_up;
						else phase_n = PH_WAIT;
					end
					PH_DROP: begin
						if (tq_cmp < w_cmp) weight_n = w_dn;
						else phase_n = PH_WAIT;
					end
					default: phase_n = PH_WAIT;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= signed'(WEIGHT_W'(START_ALPHA_RST));
			phase_q  <= PH_WAIT;
			cnt_q    <= '0;
			tgt_q    <= '0;
			lfsr_q   <= LFSR_SEED_RST;
		end else begin
			if (load.weight_ld) begin
				weight_q <= signed'(WEIGHT_W'(load.data[ALPHA_W-1:0]));
			end else if (commit) begin
				weight_q <= weight_n;
			end
			if (load.lfsr_ld) begin
				lfsr_q <= (load.data[LFSR_W-1:0] == '0) ? LFSR_W'(1) : load.data[LFSR_W-1:0];
			end else if (commit) begin
				lfsr_q <= lfsr_n;
			end
			if (commit) begin
				phase_q <= phase_n;
				cnt_q   <= cnt_n;
				tgt_q   <= tgt_n;
			end
		end
	end

	assign weight_cur  = weight_q;
	assign weight_post = weight_n;
	assign phase_post  = phase_code(phase_n);

endmodule

`default_nettype wire

@@ rtl/random_walk_crossfader_unit.sv @@
// Random-walk crossfader top level: handshakes, register file, two stages.
// Input, then result register; throughput 1 item/cycle while out_ready is high.
// The rate is set by the single 17x17 mix multiply plus the ramp FSM update in stage 1.
// Reset (arst_n low, asynchronous): registers to defaults, weight = start_alpha,
// phase wait, tick count and target zero, LFSR = seed, both stages empty.
// Depends on rwcf_pkg, rwcf_mix and rwcf_ramp.
`default_nettype none

module random_walk_crossfader_unit
	import rwcf_pkg::*;
(
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// item input channel
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          action,
	input  wire logic signed [SAMPLE_BITS-1:0] sample_a,
	input  wire logic signed [SAMPLE_BITS-1:0] sample_b,
	// result channel
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0]      mixed,
	output logic signed [WEIGHT_W-1:0]         mix_weight,
	output logic [PHASE_W-1:0]                 ramp_phase,
	// register write channel
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]          cfg_index,
	input  wire logic [CFG_DATA_W-1:0]         cfg_data
);

	// Stage 1: accepted item waiting for the mix and ramp update.
	logic                          valid_s1;
	logic                          action_s1;
	logic signed [SAMPLE_BITS-1:0] a_s1, b_s1;
	logic                          adv_s1;

	// Stage 2: result register feeding the output channel.
	logic                          valid_s2;
	logic signed [SAMPLE_BITS-1:0] mixed_s2;
	logic signed [WEIGHT_W-1:0]    weight_s2;
	logic [PHASE_W-1:0]            phase_s2;

	// Register file
	logic [TICK_W-1:0]  trans_ticks_q;
	logic [TICK_W-1:0]  incr_ticks_q;
	logic [ALPHA_W-1:0] step_size_q;
	logic               cfg_wr;
	rwcf_cfg_t          ramp_cfg;
	rwcf_load_t         ramp_load;

	logic signed [SAMPLE_BITS-1:0] mix_val;
	logic signed [WEIGHT_W-1:0]    weight_cur, weight_post;
	logic [PHASE_W-1:0]            phase_post;

	// Stage 1 moves on whenever the result register is empty or being drained;
	// a new transaction is taken in the same cycle, so a full pipe streams.
	assign adv_s1    = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || adv_s1;
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	// Register writes. start_alpha and lfsr_seed only take effect by
	// reloading the ramp state, so they are not kept here.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trans_ticks_q <= TRANS_TICKS_RST;
			incr_ticks_q  <= INCR_TICKS_RST;
			step_size_q   <= STEP_SIZE_RST;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				CFG_TRANS_TICKS: trans_ticks_q <= cfg_data[TICK_W-1:0];
				CFG_INCR_TICKS:  incr_ticks_q  <= cfg_data[TICK_W-1:0];
				CFG_STEP_SIZE:   step_size_q   <= cfg_data[ALPHA_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		ramp_cfg.transition_ticks = trans_ticks_q;
		ramp_cfg.increment_ticks  = incr_ticks_q;
		ramp_cfg.step_size        = step_size_q;
		ramp_load.weight_ld = cfg_wr && (cfg_index == CFG_START_ALPHA);
		ramp_load.lfsr_ld   = cfg_wr && (cfg_index == CFG_LFSR_SEED);
		ramp_load.data      = cfg_data;
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			action_s1 <= action;
			a_s1      <= sample_a;
			b_s1      <= sample_b;
		end
	end

	// Mix uses the weight as it stands before this item; sample items
	// leave the ramp state alone.
	rwcf_mix u_mix (
		.sample_a (a_s1),
		.sample_b (b_s1),
		.weight   (weight_cur),
		.mixed    (mix_val)
	);

	// Ramp state advances only when a tick transaction leaves stage 1.
	rwcf_ramp u_ramp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (ramp_cfg),
		.load        (ramp_load),
		.tick        (action_s1),
		.commit      (adv_s1 && action_s1),
		.weight_cur  (weight_cur),
		.weight_post (weight_post),
		.phase_post  (phase_post)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			mixed_s2  <= action_s1 ? '0 : mix_val;
			weight_s2 <= weight_post;
			phase_s2  <= phase_post;
		end
	end

	assign out_valid  = valid_s2;
	assign mixed      = mixed_s2;
	assign mix_weight = weight_s2;
	assign ramp_phase = phase_s2;

endmodule

`default_nettype wire

@@ tb/random_walk_crossfader_unit_tb.sv @@
// Self-checking testbench for random_walk_crossfader_unit: directed table, then random traffic.
// Depends on rwcf_pkg (widths, register indexes, phase codes, reset values) and the top level.
`default_nettype none

module random_walk_crossfader_unit_tb;
	import rwcf_pkg::*;

	// Run shape
	localparam int          CLK_HALF       = 6;
	localparam int          RESET_CYCLES   = 10;
	localparam int          NUM_SEGMENTS   = 8;
	localparam int          SEG_ITEMS      = 78;
	localparam int          IDLE_PCT       = 10;
	localparam int          TICK_PCT       = 60;
	localparam int          TAIL_CYCLES    = 8;
	localparam int unsigned TIMEOUT_CYCLES = 200000;

	// Item kinds on the action field
	localparam logic ACT_SAMPLE = 1'b0;
	localparam logic ACT_TICK   = 1'b1;

	// Indexes past the register list; writes there must be ignored
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;

	localparam logic signed [SAMPLE_BITS-1:0] S_HI  = 16'sh7FFF;
	localparam logic signed [SAMPLE_BITS-1:0] S_LO  = 16'sh8000;
	localparam logic signed [SAMPLE_BITS-1:0] S_ONE = 16'sd1;
	localparam logic signed [SAMPLE_BITS-1:0] S_NEG = -16'sd1;
	localparam logic signed [SAMPLE_BITS-1:0] S_0   = 16'sd0;
	localparam logic signed [WEIGHT_W-1:0]    W_RST = {1'b0, START_ALPHA_RST};
	localparam logic signed [WEIGHT_W-1:0]    W_0   = 17'sd0;
	localparam logic [CFG_DATA_W-1:0]         Q_ONE = 16'h8000;   // 1.0 in Q15

	// One result transaction
	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] mixed;
		logic signed [WEIGHT_W-1:0]    weight;
		logic [PHASE_W-1:0]            phase;
	} mix_result_t;

	// Directed stimulus: an item or a register write, optional hand-typed result
	typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

	typedef struct packed {
		row_kind_t                     kind;
		logic                          act;
		logic signed [SAMPLE_BITS-1:0] a;
		logic signed [SAMPLE_BITS-1:0] b;
		logic [CFG_IDX_W-1:0]          idx;
		logic [CFG_DATA_W-1:0]         data;
		logic                          typed;
		logic signed [SAMPLE_BITS-1:0] t_mixed;
		logic signed [WEIGHT_W-1:0]    t_weight;
		logic [PHASE_W-1:0]            t_phase;
	} stim_row_t;

	localparam int DIR_ROWS = 25;

	// Rows 6..11: fastest timing, full-scale step, seed whose first draw gives a zero
	// target, weight 0 -> the draw hits the weight exactly and no ramp follows.
	// Rows 12..18: zero seed (loads as 1), ignored index, full-scale ramp.
	// Rows 19..23: weight driven negative so the mix saturates both ways.
	localparam stim_row_t DIRECTED [DIR_ROWS] = '{
		'{ROW_ITEM, ACT_SAMPLE, S_0,  S_0,  CFG_START_ALPHA, 16'd0, 1'b1, S_0,  W_RST, CODE_WAIT},
		'{ROW_ITEM, ACT_SAMPLE, S_HI, S_HI, CFG_START_ALPHA, 16'd0, 1'b1, S_HI, W_RST, CODE_WAIT},
		'{ROW_ITEM, ACT_SAMPLE, S_LO, S_LO, CFG_START_ALPHA, 16'd0, 1'b1, S_LO, W_RST, CODE_WAIT},
		'{ROW_ITEM, ACT_SAMPLE, S_LO, S_HI, CFG_START_ALPHA, 16'd0, 1'b0, S_0,  W_0,   CODE_WAIT},
		'{ROW_ITEM, ACT_SAMPLE, S_HI, S_LO, CFG_START_ALPHA, 16'd0, 1'b0, S_0,  W_0,   CODE_WAIT},
		'{ROW_ITEM, ACT_TICK,   S_HI, S_LO, CFG_START_ALPHA, 16'd0, 1'b1, S_0,  W_RST, CODE_WAIT},
		'{ROW_REG,  ACT_SAMPLE, S_0,  S_0,  CFG_TRANS_TICKS, 16'd0, 1'b0, S_0,  W_0,   CODE_WAIT},
		'{ROW_REG,  ACT_SAMPLE, S_0,  S_0,  CFG_INCR_TICKS,  16'd0, 1'b0, S_0,  W_0,   CODE_WAIT},
		'{ROW_REG,  ACT_SAMPLE, S_0,  S_0,  CFG_STEP_SIZE,   Q_ONE, 1'b0, S_0,  W_0,   CODE_WAIT},
		'{ROW_REG,  ACT_SAMPLE, S_0,  S_0,  CFG_LFSR_SEED,   16'd2, 1'b0, S_0,  W_0,   CODE_WAIT},
		'{ROW_REG,  ACT_SAMPLE, S_0,  S_0,  CFG_START_ALPHA, 16'd0, 1'b0, S_0,  W_0,   CODE_WAIT},
		'{ROW_ITEM, ACT_TICK,   S_0,  S_0,  CFG_START_ALPHA, 16'd0, 1'b1, S_0,  W_0,   CODE_WAIT},
		'{ROW_REG,  ACT_SAMPLE, S_0,  S_0,  CFG_LFSR_SEED,   16'd0, 1'b0, S_0,  W_0,   CODE_WAIT},
		'{ROW_REG,  ACT_SAMPLE, S_0,  S_0,  CFG_UNUSED_HI, 16'hFFFF, 1'b0, S_0, W_0,   CODE_WAIT},
		'{ROW_REG,  ACT_SAMPLE, S_0,  S_0,  CFG_START_ALPHA, Q_ONE, 1'b0, S_0,  W_0,   CODE_WAIT},
		'{ROW_ITEM, ACT_TICK,   S_LO, S_HI, CFG_START_ALPHA, 16'd0, 1'b0, S_0,  W_0,   CODE_WAIT},
		'{ROW_ITEM, ACT_TICK,   S_HI, S_HI, CFG_START_ALPHA, 16'd0, 1'b0, S_0,  W_0,   CODE_WAIT},
		'{ROW_ITEM, ACT_SAMPLE, S_LO, S_HI, CFG_START_ALPHA, 16'd0, 1'b0, S_0,  W_0,   CODE_WAIT},
		'{ROW_ITEM, ACT_TICK,   S_0,  S_0,  CFG_START_ALPHA, 16'd0, 1'b0, S_0,  W_0,   CODE_WAIT},
		'{ROW_REG,  ACT_SAMPLE, S_0,  S_0,  CFG_START_ALPHA, START_ALPHA_RST, 1'b0, S_0, W_0,
			CODE_WAIT},
		'{ROW_ITEM, ACT_TICK,   S_0,  S_0,  CFG_START_ALPHA, 16'd0, 1'b0, S_0,  W_0,   CODE_WAIT},
		'{ROW_ITEM, ACT_SAMPLE, S_HI, S_LO, CFG_START_ALPHA, 16'd0, 1'b0, S_0,  W_0,   CODE_WAIT},
		'{ROW_ITEM, ACT_SAMPLE, S_LO, S_HI, CFG_START_ALPHA, 16'd0, 1'b0, S_0,  W_0,   CODE_WAIT},
		'{ROW_ITEM, ACT_TICK,   S_0,  S_0,  CFG_START_ALPHA, 16'd0, 1'b0, S_0,  W_0,   CODE_WAIT},
		'{ROW_ITEM, ACT_SAMPLE, S_ONE, S_NEG, CFG_START_ALPHA, 16'd0, 1'b0, S_0, W_0,  CODE_WAIT}
	};

	// DUT connections; every input is known from time zero
	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          in_valid  = 1'b0;
	logic                          in_ready;
	logic                          action    = ACT_SAMPLE;
	logic signed [SAMPLE_BITS-1:0] sample_a  = '0;
	logic signed [SAMPLE_BITS-1:0] sample_b  = '0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic signed [SAMPLE_BITS-1:0] mixed;
	logic signed [WEIGHT_W-1:0]    mix_weight;
	logic [PHASE_W-1:0]            ramp_phase;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [CFG_IDX_W-1:0]          cfg_index = CFG_START_ALPHA;
	logic [CFG_DATA_W-1:0]         cfg_data  = '0;

	random_walk_crossfader_unit u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.action     (action),
		.sample_a   (sample_a),
		.sample_b   (sample_b),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.mixed      (mixed),
		.mix_weight (mix_weight),
		.ramp_phase (ramp_phase),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	// Crossfader mirror: register copies and ramp state
	logic [ALPHA_W-1:0] reg_start_alpha;
	logic [TICK_W-1:0]  reg_trans_ticks;
	logic [TICK_W-1:0]  reg_incr_ticks;
	logic [ALPHA_W-1:0] reg_step_size;
	logic [LFSR_W-1:0]  reg_lfsr_seed;
	int                 fade_weight;     // kept in -65536..65535
	logic [PHASE_W-1:0] fade_phase;
	logic [TICK_W-1:0]  wait_count;
	logic [LFSR_W-1:0]  fade_target;
	logic [LFSR_W-1:0]  target_lfsr;

	// Results still owed by the DUT, oldest first
	mix_result_t pending_results [$];
	mix_result_t seen_result;
	mix_result_t owed_result;

	int       error_count = 0;
	int       sample_count = 0;
	int       tick_count_sent = 0;
	int       write_count = 0;
	bit [3:0] phases_seen = '0;
	bit       calm_stretch = 1'b0;   // no idling on either side while set

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// Watchdog: generous multiple of the slowest legal run
	initial begin
		#(TIMEOUT_CYCLES * 2 * CLK_HALF);
		$display("%0t: timeout, %0d results still owed", $time, pending_results.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// ---------------- mirror of the crossfader ----------------

	task automatic reset_crossfade();
		reg_start_alpha = START_ALPHA_RST;
		reg_trans_ticks = TRANS_TICKS_RST;
		reg_incr_ticks  = INCR_TICKS_RST;
		reg_step_size   = STEP_SIZE_RST;
		reg_lfsr_seed   = LFSR_SEED_RST;
		fade_weight     = int'(START_ALPHA_RST);
		fade_phase      = CODE_WAIT;
		wait_count      = '0;
		fade_target     = '0;
		target_lfsr     = LFSR_SEED_RST;
	endtask

	// Register write side effects: start_alpha reloads weight, seed reloads the LFSR
	task automatic load_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
		case (idx)
			CFG_START_ALPHA: begin
				reg_start_alpha = d;
				fade_weight     = int'(d);
			end
			CFG_TRANS_TICKS: reg_trans_ticks = d[TICK_W-1:0];
			CFG_INCR_TICKS:  reg_incr_ticks  = d[TICK_W-1:0];
			CFG_STEP_SIZE:   reg_step_size   = d;
			CFG_LFSR_SEED: begin
				reg_lfsr_seed = d;
				target_lfsr   = (d == '0) ? LFSR_W'(1) : d;   // zero would lock the LFSR
			end
			default: ;
		endcase
	endtask

	function automatic int clip_weight(input longint v);
		if (v > 65535)
			return 65535;
		if (v < -65536)
			return -65536;
		return int'(v);
	endfunction

	task automatic nudge_weight(input bit up);
		if (up)
			fade_weight = clip_weight(longint'(fade_weight) + longint'(reg_step_size));
		else
			fade_weight = clip_weight(longint'(fade_weight) - longint'(reg_step_size));
	endtask

	// Galois LFSR step, then scale the 16-bit value into Q15
	task automatic draw_target();
		logic out_bit;
		out_bit     = target_lfsr[0];
		target_lfsr = target_lfsr >> 1;
		if (out_bit)
			target_lfsr = target_lfsr ^ LFSR_TAPS;
		fade_target = target_lfsr >> (LFSR_W - FRAC_BITS);
	endtask

	// Reached from wait and from fall: keep falling, or pick a target and turn
	task automatic fall_or_turn();
		int tgt;
		if (fade_weight > 0) begin
			nudge_weight(1'b0);
			fade_phase = CODE_FALL;
		end else begin
			draw_target();
			tgt = int'(fade_target);
			if (tgt > fade_weight) begin
				nudge_weight(1'b1);
				fade_phase = CODE_RISE;
			end else if (tgt < fade_weight) begin
				nudge_weight(1'b0);
				fade_phase = CODE_DROP;
			end else begin
				fade_phase = CODE_WAIT;
			end
		end
	endtask

	task automatic apply_tick();
		logic [TICK_W-1:0] span;
		span = (fade_phase == CODE_WAIT) ? reg_trans_ticks : reg_incr_ticks;
		if (span == '0)
			span = TICK_W'(1);
		wait_count = wait_count + 1'b1;
		if (wait_count >= span) begin
			wait_count = '0;
			case (fade_phase)
				CODE_WAIT, CODE_FALL: fall_or_turn();
				CODE_RISE: begin
					if (int'(fade_target) > fade_weight)
						nudge_weight(1'b1);
					else
						fade_phase = CODE_WAIT;
				end
				default: begin
					if (int'(fade_target) < fade_weight)
						nudge_weight(1'b0);
					else
						fade_phase = CODE_WAIT;
				end
			endcase
		end
	endtask

	// a + (b - a) * weight, rounded half up by floor((p + 0.5 lsb)), saturated
	function automatic logic signed [SAMPLE_BITS-1:0] blend(input logic signed [SAMPLE_BITS-1:0] a,
			input logic signed [SAMPLE_BITS-1:0] b);
		longint p;
		longint s;
		p = (longint'(b) - longint'(a)) * longint'(fade_weight) + (longint'(1) << (FRAC_BITS - 1));
		s = longint'(a) + (p >>> FRAC_BITS);
		if (s > 32767)
			s = 32767;
		if (s < -32768)
			s = -32768;
		return SAMPLE_BITS'(s);
	endfunction

	task automatic advance_crossfade(input logic act, input logic signed [SAMPLE_BITS-1:0] a,
			input logic signed [SAMPLE_BITS-1:0] b, output mix_result_t r);
		if (act == ACT_TICK) begin
			apply_tick();
			r.mixed = '0;
		end else begin
			r.mixed = blend(a, b);
		end
		r.weight = WEIGHT_W'(fade_weight);
		r.phase  = fade_phase;
		phases_seen[fade_phase] = 1'b1;
	endtask

	// ---------------- drivers ----------------

	// Drop in_valid and hold until every owed result is back
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		load_register(idx, d);
		write_count++;
	endtask

	// One input transaction; the prediction is made at the accepting edge
	task automatic push_item(input logic act, input logic signed [SAMPLE_BITS-1:0] a,
			input logic signed [SAMPLE_BITS-1:0] b, input logic use_typed,
			input mix_result_t typed_res);
		mix_result_t r;
		while (!calm_stretch && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action   <= act;
		sample_a <= a;
		sample_b <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		advance_crossfade(act, a, b, r);
		pending_results.push_back(use_typed ? typed_res : r);
		if (act == ACT_TICK)
			tick_count_sent++;
		else
			sample_count++;
	endtask

	// Mostly uniform 16-bit samples, with the rails and zero mixed in
	function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
		case ($urandom_range(7))
			0: return S_HI;
			1: return S_LO;
			2: return S_0;
			default: return SAMPLE_BITS'($urandom);
		endcase
	endfunction

	// ---------------- result checker ----------------

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			seen_result = '{mixed, mix_weight, ramp_phase};
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result mixed=%0d weight=%0d phase=%0d",
					$time, mixed, mix_weight, ramp_phase);
				error_count++;
			end else begin
				owed_result = pending_results.pop_front();
				if (seen_result !== owed_result) begin
					$display("%0t: mismatch expected mixed=%0d weight=%0d phase=%0d, %s",
						$time, owed_result.mixed, owed_result.weight, owed_result.phase,
						$sformatf("got mixed=%0d weight=%0d phase=%0d",
						seen_result.mixed, seen_result.weight, seen_result.phase));
					error_count++;
				end
			end
		end
		out_ready <= calm_stretch || ($urandom_range(99) >= IDLE_PCT);
	end

	// ---------------- stimulus ----------------

	initial begin
		stim_row_t          row;
		mix_result_t        typed_res;
		logic               act;
		logic [ALPHA_W-1:0] s_alpha;
		logic [TICK_W-1:0]  s_trans;
		logic [TICK_W-1:0]  s_incr;
		logic [ALPHA_W-1:0] s_step;
		logic [LFSR_W-1:0]  s_seed;

		reset_crossfade();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: reset values, rails, tick timing edge cases
		for (int i = 0; i < DIR_ROWS; i++) begin
			row = DIRECTED[i];
			if (row.kind == ROW_REG) begin
				write_reg(row.idx, row.data);
			end else begin
				typed_res = '{row.t_mixed, row.t_weight, row.t_phase};
				push_item(row.act, row.a, row.b, row.typed, typed_res);
			end
		end

		// Random part: each segment runs under its own register setting
		for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
			case (seg)
				0: begin
					// fastest ramp, full-scale steps
					s_alpha = '0;
					s_trans = '0;
					s_incr  = '0;
					s_step  = Q_ONE;
					s_seed  = LFSR_W'(1);
				end
				1: begin
					// longest waits, frozen ramp
					s_alpha = Q_ONE;
					s_trans = '1;
					s_incr  = '1;
					s_step  = '0;
					s_seed  = '1;
				end
				default: begin
					s_alpha = ALPHA_W'($urandom_range(32768));
					s_trans = TICK_W'($urandom_range(3));
					s_incr  = TICK_W'($urandom_range(2));
					s_step  = ($urandom_range(3) == 0) ? ALPHA_W'($urandom_range(32768))
						: ALPHA_W'($urandom_range(8192, 256));
					s_seed  = LFSR_W'($urandom_range(65535));
				end
			endcase
			write_reg(CFG_START_ALPHA, s_alpha);
			write_reg(CFG_TRANS_TICKS, CFG_DATA_W'(s_trans));
			write_reg(CFG_INCR_TICKS, CFG_DATA_W'(s_incr));
			write_reg(CFG_STEP_SIZE, s_step);
			write_reg(CFG_LFSR_SEED, s_seed);
			if (seg[0])
				write_reg(CFG_IDX_W'($urandom_range(CFG_UNUSED_HI, CFG_UNUSED_LO)),
					CFG_DATA_W'($urandom));

			for (int k = 0; k < SEG_ITEMS; k++) begin
				calm_stretch = (seg == 4);
				// one full stop of the sender mid-run
				if (seg == 3 && k == SEG_ITEMS / 2)
					drain_results();
				act = ($urandom_range(99) < TICK_PCT) ? ACT_TICK : ACT_SAMPLE;
				push_item(act, pick_sample(), pick_sample(), 1'b0, '0);
			end
		end
		calm_stretch = 1'b0;

		// Let the pipe empty, then keep watching for stray results
		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Checked %0d sample and %0d tick transactions with %0d register writes;",
			sample_count, tick_count_sent, write_count);
		$display("ramp phase codes reached (bit per code): %b", phases_seen);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

`default_nettype wire
